// ===== src/nlms_pkg.sv =====
// nlms_pkg: shared types and constants of the nlms echo canceller
// used by nlms_ctrl, nlms_dp and nlms_echo_canceller; no dependencies
package nlms_pkg;

   // register indexes of the configuration port
   localparam logic [1:0] CSR_STEP_SIZE   = 2'd0;
   localparam logic [1:0] CSR_TAPS_IN_USE = 2'd1;

   localparam logic [15:0] STEP_SIZE_RESET   = 16'd6554;
   localparam logic [6:0]  TAPS_IN_USE_RESET = 7'd64;

   localparam int FRAC_BITS = 28;
   localparam int DIV_STEPS = 64;

   // commands from the controller to the datapath
   typedef struct packed {
      logic clr;        // write zeros to both stores at the index
      logic accept;     // take a transaction, push the reference sample
      logic issue;      // read tap at the index
      logic upd;        // pass is a coefficient update (else dot product)
      logic err_calc;   // form the error
      logic load_rsp;   // load the result register
      logic mul_lo;     // low partial product of mu * |e|
      logic mul_hi;     // high partial product, load the divider
      logic div_step;   // one restoring division step
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;   // result register can take a result
   } dp_sts_type;

endpackage

// ===== src/nlms_ctrl.sv =====
// nlms_ctrl: sequencing state machine of the nlms echo canceller
// depends on nlms_pkg
module nlms_ctrl #(
   parameter int MAX_TAPS = 64,
   localparam int CW  = ($clog2(MAX_TAPS + 2) > 7) ? $clog2(MAX_TAPS + 2) : 7,
   localparam int AIW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [CW-1:0]            taps_n,
   input  nlms_pkg::dp_sts_type     sts,
   output nlms_pkg::dp_cmd_type     cmd,
   output logic [AIW-1:0]           idx
);
   typedef enum logic [8:0] {
      ST_CLEAR = 9'b000000001,
      ST_IDLE  = 9'b000000010,
      ST_MAC   = 9'b000000100,
      ST_ERR   = 9'b000001000,
      ST_OUT   = 9'b000010000,
      ST_MULLO = 9'b000100000,
      ST_MULHI = 9'b001000000,
      ST_DIV   = 9'b010000000,
      ST_UPD   = 9'b100000000
   } state_type;

   state_type      state_ff, state_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           pass_done;

   assign pass_done = (cnt_ff == taps_n + CW'(1));
   assign idx       = cnt_ff[AIW-1:0];

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff + CW'(1);
      cmd      = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr = 1'b1;
            if (cnt_ff == CW'(MAX_TAPS - 1)) begin
               state_in = ST_IDLE;
               cnt_in   = '0;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            cnt_in     = '0;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = ST_MAC;
            end
         end
         ST_MAC: begin
            cmd.issue = (cnt_ff < taps_n);
            if (pass_done) begin
               state_in = ST_ERR;
               cnt_in   = '0;
            end
         end
         ST_ERR: begin
            cmd.err_calc = 1'b1;
            state_in     = ST_OUT;
         end
         ST_OUT: begin
            if (sts.out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_MULLO;
            end
         end
         ST_MULLO: begin
            cmd.mul_lo = 1'b1;
            state_in   = ST_MULHI;
         end
         ST_MULHI: begin
            cmd.mul_hi = 1'b1;
            state_in   = ST_DIV;
            cnt_in     = '0;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == CW'(nlms_pkg::DIV_STEPS - 1)) begin
               state_in = ST_UPD;
               cnt_in   = '0;
            end
         end
         ST_UPD: begin
            cmd.upd   = 1'b1;
            cmd.issue = (cnt_ff < taps_n);
            if (pass_done) begin
               state_in = ST_IDLE;
               cnt_in   = '0;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            cnt_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ===== src/nlms_dp.sv =====
// nlms_dp: datapath of the nlms echo canceller: history and coefficient
// memories, multiply-accumulate pipeline, error, divider, result register; uses nlms_pkg
module nlms_dp #(
   parameter int MAX_TAPS = 64,
   localparam int AIW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  nlms_pkg::dp_cmd_type  cmd,
   output nlms_pkg::dp_sts_type  sts,
   input  logic [AIW-1:0]        idx,
   input  logic [15:0]           step_size,
   input  logic signed [15:0]    mic_sample,
   input  logic signed [15:0]    reference_sample,
   input  logic                  last_in_frame,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [15:0]           cleaned_sample,
   output logic                  clipped,
   output logic                  frame_end
);
   localparam int AW  = 48 + $clog2(MAX_TAPS + 1);
   localparam int EW  = AW + 1;
   localparam int PW  = 31 + $clog2(MAX_TAPS + 1);
   localparam logic signed [EW-1:0] ERR_HI = {{(EW-44){1'b0}}, 16'h7FFF, 28'h0};
   localparam logic signed [EW-1:0] ERR_LO = {{(EW-44){1'b1}}, 16'h8000, 28'h0};

   logic signed [15:0] hist_mem [MAX_TAPS];
   logic signed [31:0] coef_mem [MAX_TAPS];

   logic [AIW-1:0]        head_ff, head_next, raddr;
   logic [AIW:0]          diff;
   logic signed [15:0]    mic_ff;
   logic                  last_ff;
   logic signed [15:0]    x1_ff;
   logic signed [31:0]    c1_ff, c2_ff;
   logic                  s1_v_ff, s2_v_ff;
   logic [AIW-1:0]        i1_ff, i2_ff;
   logic signed [47:0]    prod_ff;
   logic [30:0]           sq_ff;
   logic [47:0]           pl_ff, ph_ff;
   logic                  sgn2_ff;
   logic signed [AW-1:0]  acc_ff;
   logic [PW-1:0]         pw_ff;
   logic signed [EW-1:0]  err_ff;
   logic                  eneg_ff;
   logic [47:0]           emag_ff;
   logic [39:0]           plo_ff;
   logic [63:0]           q_ff;
   logic [PW-1:0]         rem_ff;
   logic                  rsp_v_ff;
   logic [15:0]           clean_ff;
   logic                  clip_ff, fend_ff;

   logic [EW-1:0]  eabs;
   logic           e_neg, sat_pos, sat_neg;
   logic [15:0]    mag16, clean_v;
   logic           clip_v;
   logic [47:0]    emag_v;
   logic [39:0]    phi_v;
   logic [15:0]    ax;
   logic [PW:0]    rem_sh, rem_diff;
   logic [63:0]    dfull;
   logic [33:0]    dc;
   logic signed [34:0] csum;
   logic signed [31:0] cnew;

   assign head_next = (head_ff == AIW'(MAX_TAPS - 1)) ? '0 : head_ff + AIW'(1);
   assign diff  = {1'b0, head_ff} - {1'b0, idx};
   assign raddr = diff[AIW] ? AIW'(diff + (AIW + 1)'(MAX_TAPS)) : diff[AIW-1:0];

   // history memory
   always_ff @(posedge clock) begin
      if (cmd.clr)
         hist_mem[idx] <= '0;
      else if (cmd.accept)
         hist_mem[head_next] <= reference_sample;
      x1_ff <= hist_mem[raddr];
   end

   // coefficient memory, written back from the last pipeline stage
   always_ff @(posedge clock) begin
      if (cmd.clr)
         coef_mem[idx] <= '0;
      else if (cmd.upd && s2_v_ff)
         coef_mem[i2_ff] <= cnew;
      c1_ff <= coef_mem[idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         if (cmd.accept)
            head_ff <= head_next;
         s1_v_ff <= cmd.issue;
         s2_v_ff <= s1_v_ff;
         if (cmd.load_rsp)
            rsp_v_ff <= 1'b1;
         else if (rsp_tready)
            rsp_v_ff <= 1'b0;
      end
   end

   // stage two: products
   assign ax = x1_ff[15] ? 16'(-x1_ff) : 16'(x1_ff);

   always_ff @(posedge clock) begin
      i1_ff   <= idx;
      i2_ff   <= i1_ff;
      c2_ff   <= c1_ff;
      prod_ff <= c1_ff * x1_ff;
      sq_ff   <= 31'(32'(x1_ff) * 32'(x1_ff));
      pl_ff   <= q_ff[31:0] * ax;
      ph_ff   <= q_ff[63:32] * ax;
      sgn2_ff <= eneg_ff ^ x1_ff[15];
   end

   // stage three: coefficient step, clamped before the saturating add
   assign dfull = {ph_ff[47:0], 16'h0} + {32'h0, pl_ff[47:16]};
   assign dc    = (|dfull[63:33]) ? {1'b1, 33'h0} : {1'b0, dfull[32:0]};
   assign csum  = sgn2_ff ? (35'(c2_ff) - $signed({1'b0, dc}))
                          : (35'(c2_ff) + $signed({1'b0, dc}));
   always_comb begin
      if (csum > 35'sh0_7FFF_FFFF)
         cnew = 32'sh7FFF_FFFF;
      else if (csum < -35'sh0_8000_0000)
         cnew = 32'sh8000_0000;
      else
         cnew = csum[31:0];
   end

   // error, result and update error magnitude
   assign e_neg   = err_ff[EW-1];
   assign eabs    = e_neg ? EW'(-err_ff) : EW'(err_ff);
   assign sat_pos = !e_neg && (|err_ff[EW-1:47]);
   assign sat_neg = e_neg && !(&err_ff[EW-1:47]);
   assign emag_v  = sat_pos ? 48'h7FFF_FFFF_FFFF : (sat_neg ? 48'h8000_0000_0000
                                                            : eabs[47:0]);
   assign mag16   = eabs[43:28];
   always_comb begin
      clip_v = 1'b1;
      if (err_ff > ERR_HI)
         clean_v = 16'h7FFF;
      else if (err_ff < ERR_LO)
         clean_v = 16'h8000;
      else begin
         clip_v  = 1'b0;
         clean_v = e_neg ? 16'(-mag16) : mag16;
      end
   end

   // high partial product of mu * |e|
   assign phi_v = step_size * emag_ff[47:24];

   assign rem_sh   = {rem_ff, q_ff[63]};
   assign rem_diff = rem_sh - {1'b0, pw_ff};

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mic_ff  <= mic_sample;
         last_ff <= last_in_frame;
         acc_ff  <= '0;
         pw_ff   <= PW'(1);
      end else if (!cmd.upd && s2_v_ff) begin
         acc_ff <= acc_ff + AW'(prod_ff);
         pw_ff  <= pw_ff + PW'(sq_ff);
      end
      if (cmd.err_calc)
         err_ff <= EW'($signed({mic_ff, 28'h0})) - EW'(acc_ff);
      if (cmd.load_rsp) begin
         clean_ff <= clean_v;
         clip_ff  <= clip_v;
         fend_ff  <= last_ff;
         eneg_ff  <= e_neg;
         emag_ff  <= emag_v;
      end
      if (cmd.mul_lo)
         plo_ff <= step_size * emag_ff[23:0];
      if (cmd.mul_hi) begin
         q_ff   <= {24'h0, plo_ff} + {phi_v, 24'h0};
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         if (!rem_diff[PW]) begin
            rem_ff <= rem_diff[PW-1:0];
            q_ff   <= {q_ff[62:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[PW-1:0];
            q_ff   <= {q_ff[62:0], 1'b0};
         end
      end
   end

   assign sts.out_free   = !rsp_v_ff || rsp_tready;
   assign rsp_tvalid     = rsp_v_ff;
   assign cleaned_sample = clean_ff;
   assign clipped        = clip_ff;
   assign frame_end      = fend_ff;

endmodule

// ===== src/nlms_echo_canceller.sv =====
// nlms_echo_canceller: top level, configuration registers and stream ports
// instantiates nlms_ctrl and nlms_dp; uses nlms_pkg
//
// nlms acoustic echo canceller. each req transaction carries a microphone
// and a far-end reference sample; one rsp transaction returns the cleaned
// sample. an item runs a serial multiply-accumulate pass over the n active
// taps through one read port of each memory, a 64-step restoring divider
// for the normalization, and a serial coefficient update pass. the result
// is issued after the first pass and waits in an output register while
// the update runs. after reset a clearing pass over all MAX_TAPS entries
// zeroes both memories, during which req_tready stays low; csr writes are
// taken at any time but belong to idle periods.
module nlms_echo_canceller #(
   parameter int MAX_TAPS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // mic_sample [15:0], reference_sample [31:16]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // cleaned_sample [15:0]
   output logic        rsp_tuser,   // clipped [0]
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   localparam int CW  = ($clog2(MAX_TAPS + 2) > 7) ? $clog2(MAX_TAPS + 2) : 7;
   localparam int AIW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

   logic [15:0]          step_ff, step_in;
   logic [6:0]           taps_ff, taps_in;
   logic [CW-1:0]        taps_n;
   nlms_pkg::dp_cmd_type cmd;
   nlms_pkg::dp_sts_type sts;
   logic [AIW-1:0]       idx;

   // configuration writes, unknown index ignored
   always_comb begin
      step_in = step_ff;
      taps_in = taps_ff;
      if (csr_we) begin
         unique case (csr_index)
            nlms_pkg::CSR_STEP_SIZE:   step_in = csr_wdata;
            nlms_pkg::CSR_TAPS_IN_USE: taps_in = csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= nlms_pkg::STEP_SIZE_RESET;
         taps_ff <= nlms_pkg::TAPS_IN_USE_RESET;
      end else begin
         step_ff <= step_in;
         taps_ff <= taps_in;
      end
   end

   // active taps: zero means one, clamp to the built depth
   always_comb begin
      if (taps_ff == '0)
         taps_n = CW'(1);
      else if (CW'(taps_ff) > CW'(MAX_TAPS))
         taps_n = CW'(MAX_TAPS);
      else
         taps_n = CW'(taps_ff);
   end

   nlms_ctrl #(.MAX_TAPS(MAX_TAPS)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .taps_n     (taps_n),
      .sts        (sts),
      .cmd        (cmd),
      .idx        (idx)
   );

   nlms_dp #(.MAX_TAPS(MAX_TAPS)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .idx              (idx),
      .step_size        (step_ff),
      .mic_sample       (req_tdata[15:0]),
      .reference_sample (req_tdata[31:16]),
      .last_in_frame    (req_tlast),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .cleaned_sample   (rsp_tdata),
      .clipped          (rsp_tuser),
      .frame_end        (rsp_tlast)
   );

`ifndef SYNTH
   // clearing pass follows reset
   a_clear_after_reset: assert property (@(posedge clock) reset |=> !req_tready)
      else $error("req_tready high right after reset");
   // one item at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("req_tready high right after an accepted transaction");
   // a clipped result is a saturated value
   a_clip_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == 16'h7FFF || rsp_tdata == 16'h8000))
      else $error("clipped flag with unsaturated sample");
`endif

endmodule
